>>> rtl/rfid_pkg.sv
// Package: item types, codes, constants and states of the RFID tag line parser and tally.
package rfid_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_COUNT_BITS  = 16;

    localparam int TAG_HALF_W = 64;
    localparam int SEEN_W     = 16;
    localparam int KEPT_W     = 6;
    localparam int SLOT_W     = 6;

    localparam logic [KEPT_W-1:0] TAG_CHARS = 6'd33;

    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FIRST = 8'h21;
    localparam logic [7:0] CH_LAST  = 8'h7E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] HEX_A_OFS = 8'h37;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic RES_TAG  = 1'b0;
    localparam logic RES_READ = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        byte_value;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic                  result_kind;
        logic [TAG_HALF_W-1:0] tag_upper;
        logic [TAG_HALF_W-1:0] tag_lower;
        logic [SEEN_W-1:0]     seen_count;
        logic                  slot_valid;
        logic                  table_overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/rfid_tag_line_parser_tally.sv
// Top level: RFID reader line parser with a tag tally table.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) carries items of three
// kinds: a received byte, a table clear, or a slot read. Output channel
// (o_out_valid / i_out_ready, payload o_out) carries at most one result per item.
// Config: i_cfg_we / i_cfg_data write capture_enable; writing 0 restarts the line.
//
// Timing: a byte that does not end a line and a clear are handled in the idle
// state, and the block stays ready for further items. A slot read passes
// through the read and emit states to its result. A line end with a valid tag
// walks the table one slot per cycle through the single RAM read port and one
// 128-bit compare, then emits its result. No item is taken during a walk or read.
// A finished result sits in an output register; while the receiver stalls, new
// items are still taken until another result needs that register, and the block
// then waits in its emit state.
// Reset empties the table, clears capture_enable and restarts the line. The
// table RAM is not cleared; the fill count marks which slots hold tags.
module rfid_tag_line_parser_tally #(
    parameter int TABLE_DEPTH = rfid_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_BITS  = rfid_pkg::DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rfid_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rfid_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW   = (CW > rfid_pkg::SLOT_W) ? CW : rfid_pkg::SLOT_W;
    localparam int TW     = 2 * rfid_pkg::TAG_HALF_W;
    localparam int EW     = TW + COUNT_BITS;
    localparam int CNT_XW = (COUNT_BITS > rfid_pkg::SEEN_W) ? COUNT_BITS : rfid_pkg::SEEN_W;

    rfid_pkg::t_state r_state, n_state;

    logic                              r_capture, n_capture;
    logic [rfid_pkg::TAG_HALF_W-1:0]   r_upper, n_upper;
    logic [rfid_pkg::TAG_HALF_W-1:0]   r_lower, n_lower;
    logic [rfid_pkg::KEPT_W-1:0]       r_kept, n_kept;
    logic                              r_wf, n_wf;
    logic [CW-1:0]                     r_filled, n_filled;
    logic [CW-1:0]                     r_idx, n_idx;
    logic                              r_qv, n_qv;
    logic [AW-1:0]                     r_qidx, n_qidx;
    logic                              r_rd_ok, n_rd_ok;
    rfid_pkg::t_out_item               r_pend, n_pend;
    rfid_pkg::t_out_item               r_out, n_out;
    logic                              r_out_vld, n_out_vld;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;

    logic [TW-1:0]          q_tag;
    logic [COUNT_BITS-1:0]  q_cnt;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [CNT_XW-1:0]      cnt_inc_x;
    logic [CNT_XW-1:0]      q_cnt_x;
    logic                   hit;
    logic                   out_free;

    rfid_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign q_tag     = ram_rdata[EW-1:COUNT_BITS];
    assign q_cnt     = ram_rdata[COUNT_BITS-1:0];
    assign cnt_inc   = (&q_cnt) ? q_cnt : q_cnt + COUNT_BITS'(1);
    assign cnt_inc_x = CNT_XW'(cnt_inc);
    assign q_cnt_x   = CNT_XW'(q_cnt);
    assign hit       = r_qv && (q_tag == {r_upper, r_lower});
    assign out_free  = !r_out_vld || i_out_ready;

    assign o_in_ready  = (r_state == rfid_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        logic [7:0] c;
        logic [7:0] h;
        logic       is_hex;
        logic       restart;

        n_state   = r_state;
        n_capture = r_capture;
        n_upper   = r_upper;
        n_lower   = r_lower;
        n_kept    = r_kept;
        n_wf      = r_wf;
        n_filled  = r_filled;
        n_idx     = r_idx;
        n_qv      = r_qv;
        n_qidx    = r_qidx;
        n_rd_ok   = r_rd_ok;
        n_pend    = r_pend;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        ram_we    = 1'b0;
        ram_waddr = r_qidx;
        ram_wdata = {r_upper, r_lower, cnt_inc};
        ram_raddr = AW'(i_in.slot_index);
        restart   = 1'b0;

        c = i_in.byte_value;
        if (c >= rfid_pkg::CH_LA && c <= rfid_pkg::CH_LZ) begin
            c = c - rfid_pkg::CASE_OFS;
        end
        is_hex = 1'b1;
        h      = 8'd0;
        if (c >= rfid_pkg::CH_0 && c <= rfid_pkg::CH_9) begin
            h = c - rfid_pkg::CH_0;
        end else if (c >= rfid_pkg::CH_A && c <= rfid_pkg::CH_F) begin
            h = c - rfid_pkg::HEX_A_OFS;
        end else begin
            is_hex = 1'b0;
        end

        case (r_state)
            rfid_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.kind)
                        rfid_pkg::KIND_BYTE: begin
                            if (!r_capture) begin
                                restart = 1'b1;
                            end else if (i_in.byte_value == rfid_pkg::CH_LF) begin
                                if (r_wf && r_kept == rfid_pkg::TAG_CHARS) begin
                                    n_state = rfid_pkg::ST_SCAN;
                                    n_idx   = '0;
                                    n_qv    = 1'b0;
                                end else begin
                                    restart = 1'b1;
                                end
                            end else if (i_in.byte_value >= rfid_pkg::CH_FIRST &&
                                         i_in.byte_value <= rfid_pkg::CH_LAST) begin
                                if (r_kept >= rfid_pkg::TAG_CHARS) begin
                                    n_wf = 1'b0;
                                end else begin
                                    n_kept = r_kept + rfid_pkg::KEPT_W'(1);
                                    if (r_kept == '0) begin
                                        if (c != rfid_pkg::CH_U) begin
                                            n_wf = 1'b0;
                                        end
                                    end else if (!is_hex) begin
                                        n_wf = 1'b0;
                                    end else begin
                                        n_upper = {r_upper[59:0], r_lower[63:60]};
                                        n_lower = {r_lower[59:0], h[3:0]};
                                    end
                                end
                            end
                        end
                        rfid_pkg::KIND_CLEAR: begin
                            n_filled = '0;
                        end
                        rfid_pkg::KIND_READ: begin
                            n_state = rfid_pkg::ST_READ;
                            n_rd_ok = CMPW'(i_in.slot_index) < CMPW'(r_filled);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rfid_pkg::ST_SCAN: begin
                ram_raddr = r_idx[AW-1:0];
                n_idx     = r_idx + CW'(1);
                n_qv      = r_idx < r_filled;
                n_qidx    = r_idx[AW-1:0];
                n_pend.result_kind    = rfid_pkg::RES_TAG;
                n_pend.tag_upper      = r_upper;
                n_pend.tag_lower      = r_lower;
                n_pend.table_overflow = 1'b0;
                n_pend.slot_valid     = 1'b1;
                if (hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_qidx;
                    ram_wdata = {r_upper, r_lower, cnt_inc};
                    n_pend.seen_count = cnt_inc_x[rfid_pkg::SEEN_W-1:0];
                    n_state = rfid_pkg::ST_EMIT;
                    restart = 1'b1;
                end else if (r_idx >= r_filled) begin
                    if (r_filled < CW'(TABLE_DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_filled[AW-1:0];
                        ram_wdata = {r_upper, r_lower, COUNT_BITS'(1)};
                        n_filled  = r_filled + CW'(1);
                        n_pend.seen_count = rfid_pkg::SEEN_W'(1);
                    end else begin
                        n_pend.seen_count     = '0;
                        n_pend.slot_valid     = 1'b0;
                        n_pend.table_overflow = 1'b1;
                    end
                    n_state = rfid_pkg::ST_EMIT;
                    restart = 1'b1;
                end
            end
            rfid_pkg::ST_READ: begin
                n_pend.result_kind    = rfid_pkg::RES_READ;
                n_pend.table_overflow = 1'b0;
                n_pend.slot_valid     = r_rd_ok;
                if (r_rd_ok) begin
                    n_pend.tag_upper  = q_tag[TW-1:rfid_pkg::TAG_HALF_W];
                    n_pend.tag_lower  = q_tag[rfid_pkg::TAG_HALF_W-1:0];
                    n_pend.seen_count = q_cnt_x[rfid_pkg::SEEN_W-1:0];
                end else begin
                    n_pend.tag_upper  = '0;
                    n_pend.tag_lower  = '0;
                    n_pend.seen_count = '0;
                end
                n_state = rfid_pkg::ST_EMIT;
            end
            rfid_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out     = r_pend;
                    n_out_vld = 1'b1;
                    n_state   = rfid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rfid_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_capture = i_cfg_data;
            if (!i_cfg_data) begin
                restart = 1'b1;
            end
        end

        if (restart) begin
            n_upper = '0;
            n_lower = '0;
            n_kept  = '0;
            n_wf    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rfid_pkg::ST_IDLE;
            r_capture <= 1'b0;
            r_upper   <= '0;
            r_lower   <= '0;
            r_kept    <= '0;
            r_wf      <= 1'b1;
            r_filled  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_capture <= n_capture;
            r_upper   <= n_upper;
            r_lower   <= n_lower;
            r_kept    <= n_kept;
            r_wf      <= n_wf;
            r_filled  <= n_filled;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_qv    <= n_qv;
        r_qidx  <= n_qidx;
        r_rd_ok <= n_rd_ok;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

endmodule

>>> rtl/rfid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
